[rtl/core/utf16_sampled_string_hash_unit_macros.svh]
// Assertion macros used by the checker of the string hash unit.
`ifndef UTF16_SAMPLED_STRING_HASH_UNIT_MACROS_SVH
`define UTF16_SAMPLED_STRING_HASH_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define U16SH_ASSERT_NOW(lbl, clock, reset, ante, cons) \
  lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define U16SH_ASSERT_NEXT(lbl, clock, reset, ante, cons) \
  lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

// Next-cycle implication that also holds through reset.
`define U16SH_ASSERT_ALWAYS_NEXT(lbl, clock, ante, cons) \
  lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
    else $error("%m: reset check failed");

`endif

[rtl/core/u16sh_pkg.sv]
// Types, constants and helper functions of the string hash unit.
package u16sh_pkg;

  typedef enum logic {
    OP_BEGIN = 1'b0,
    OP_UNIT  = 1'b1
  } op_t;

  localparam logic [31:0] SampleAllLimit = 32'd96;
  localparam logic [31:0] WindowUnits    = 32'd32;
  localparam logic [31:0] HalfWindow     = 32'd16;
  localparam int          MultShift      = 8;

  typedef struct packed {
    op_t         op;
    logic [15:0] code_unit;
    logic [31:0] buffer_length;
    logic [31:0] original_length;
  } req_t;

  typedef struct packed {
    logic        emit;
    logic [31:0] hash;
  } res_t;

  typedef struct packed {
    logic        sample_all;
    logic [31:0] mid_start;
    logic [31:0] last_start;
  } window_t;

  function automatic logic [31:0] finish_hash(input logic [31:0] a, input logic [4:0] s);
    return a + (a << s);
  endfunction

  function automatic logic [31:0] mult_add(input logic [31:0] a, input logic [15:0] unit);
    return a + (a << MultShift) + {16'd0, unit};
  endfunction

endpackage

[rtl/core/u16sh_sampler.sv]
// Decides whether the code unit at the current position updates the hash.
module u16sh_sampler (
  input  u16sh_pkg::window_t win,
  input  logic [31:0]        pos,
  output logic               counts
);

  logic [31:0] mid_offset;

  always_comb begin
    mid_offset = pos - win.mid_start;
    counts = win.sample_all
          || (pos < u16sh_pkg::WindowUnits)
          || ((pos >= win.mid_start) && (mid_offset < u16sh_pkg::WindowUnits))
          || (pos >= win.last_start);
  end

endmodule

[rtl/core/u16sh_core.sv]
// String state and hash accumulator, updated by one request per step.
module u16sh_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  u16sh_pkg::req_t   req,
  output u16sh_pkg::res_t   res
);

  logic [31:0]        accumulator;
  logic [31:0]        position;
  logic [31:0]        expected_count;
  logic [4:0]         shift_amount;
  logic               string_open;
  u16sh_pkg::window_t win;

  logic               counts;
  logic [31:0]        accumulator_next;
  logic [31:0]        position_next;
  logic               done;

  u16sh_sampler u_sampler (
    .win    (win),
    .pos    (position),
    .counts (counts)
  );

  always_comb begin
    accumulator_next = counts ? u16sh_pkg::mult_add(accumulator, req.code_unit) : accumulator;
    position_next    = position + 32'd1;
    done             = (position_next >= expected_count);
    res.emit         = 1'b0;
    res.hash         = u16sh_pkg::finish_hash(accumulator_next, shift_amount);
    case (req.op)
      u16sh_pkg::OP_BEGIN: begin
        if (req.original_length == 32'd0) begin
          res.emit = 1'b1;
          res.hash = 32'd0;
        end else if (req.buffer_length == 32'd0) begin
          res.emit = 1'b1;
          res.hash = u16sh_pkg::finish_hash(req.original_length, req.original_length[4:0]);
        end
      end
      u16sh_pkg::OP_UNIT: begin
        res.emit = string_open && done;
      end
      default: begin
        res.emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator    <= '0;
      position       <= '0;
      expected_count <= '0;
      shift_amount   <= '0;
      string_open    <= 1'b0;
      win            <= '0;
    end else if (step) begin
      case (req.op)
        u16sh_pkg::OP_BEGIN: begin
          string_open    <= (req.original_length != 32'd0) && (req.buffer_length != 32'd0);
          position       <= '0;
          shift_amount   <= req.original_length[4:0];
          accumulator    <= req.original_length;
          expected_count <= req.buffer_length;
          win.sample_all <= (req.buffer_length <= u16sh_pkg::SampleAllLimit);
          win.mid_start  <= (req.buffer_length >> 1) - u16sh_pkg::HalfWindow;
          win.last_start <= req.buffer_length - u16sh_pkg::WindowUnits;
        end
        u16sh_pkg::OP_UNIT: begin
          if (string_open) begin
            accumulator <= accumulator_next;
            position    <= position_next;
            if (done) begin
              string_open <= 1'b0;
            end
          end
        end
        default: begin
          string_open <= string_open;
        end
      endcase
    end
  end

endmodule

[rtl/core/utf16_sampled_string_hash_unit.sv]
// Top level of the sampled UTF-16 string hash unit.
//
// Requests arrive on the input channel (in_valid, in_stall). A begin request
// carries the buffered unit count and the original length; each unit request
// carries one UTF-16 code unit. Results leave on the output channel
// (out_valid, out_stall) as one 32-bit hash_value per finished string.
// A begin request with an empty original string or an empty buffer gives its
// result at once; otherwise the result follows the last unit request.
// Every request is captured in an input register and then processed into
// the state and result registers, so a result is offered from the result
// register after the request that completes it leaves the input register.
// One request is accepted per cycle while the input channel does not stall;
// the multiply by 257 is a shift and add, so the accumulator update is combinational.
// Reset clears the valid flags of both registers and the string state, leaving no string open.
// While the receiver stalls, the result is held; the input register still
// fills, and the input channel stalls once it holds a request that waits.
module utf16_sampled_string_hash_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [15:0] code_unit,
  input  logic [31:0] buffer_length,
  input  logic [31:0] original_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] hash_value
);

  logic            s1_valid;
  u16sh_pkg::req_t s1_req;
  logic            out_free;
  logic            step;
  u16sh_pkg::res_t res;

  assign out_free = !out_valid || !out_stall;
  assign step     = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_req.op              <= u16sh_pkg::op_t'(op);
      s1_req.code_unit       <= code_unit;
      s1_req.buffer_length   <= buffer_length;
      s1_req.original_length <= original_length;
    end
  end

  u16sh_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .req  (s1_req),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.emit) begin
      hash_value <= res.hash;
    end
  end

endmodule

[rtl/core/u16sh_checker.sv]
// Port-level checker of the string hash unit and its bind.
`include "utf16_sampled_string_hash_unit_macros.svh"

module u16sh_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        op,
  input logic [15:0] code_unit,
  input logic [31:0] buffer_length,
  input logic [31:0] original_length,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] hash_value
);

  `U16SH_ASSERT_ALWAYS_NEXT(a_reset_empties_output, clk, rst, !out_valid)
  `U16SH_ASSERT_NOW(a_stall_only_when_blocked, clk, rst, in_stall, out_valid && out_stall)
  `U16SH_ASSERT_NEXT(a_result_held, clk, rst, out_valid && out_stall, out_valid && $stable(hash_value))

endmodule

bind utf16_sampled_string_hash_unit u16sh_checker u_u16sh_checker (.*);

[tb/sv/tb_utf16_sampled_string_hash_unit.sv]
// Self-checking testbench of the sampled UTF-16 string hash unit, with randomised handshakes.
`timescale 1ns / 100ps

module tb_utf16_sampled_string_hash_unit;

  localparam int          IdleLimit      = 1000;
  localparam int          MaxWait        = 13;
  localparam int          ReportLimit    = 50;
  localparam int          RandomRequests = 200;
  localparam logic [31:0] HashMultiplier = 32'd257;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        op;
  logic [15:0] code_unit;
  logic [31:0] buffer_length;
  logic [31:0] original_length;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] hash_value;

  logic [31:0] expected_hashes[$];
  logic [31:0] oldest_hash;

  logic [31:0] acc_model;
  logic [31:0] pos_model;
  logic [31:0] count_model;
  logic [4:0]  shift_model;
  logic        open_model;

  int error_count   = 0;
  int request_count = 0;
  int idle_cycles   = 0;
  int tx_max_gap    = MaxWait;
  int rx_max_stall  = MaxWait;
  int rx_wait       = 0;
  int hold_left     = 0;

  utf16_sampled_string_hash_unit DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .op             (op),
    .code_unit      (code_unit),
    .buffer_length  (buffer_length),
    .original_length(original_length),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .hash_value     (hash_value)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] finalise_hash(input logic [31:0] a, input logic [4:0] s);
    return a + (a << s);
  endfunction

  function automatic bit unit_sampled(input logic [31:0] idx, input logic [31:0] len);
    logic [31:0] mid;
    mid = (len >> 1) - u16sh_pkg::HalfWindow;
    if (len <= u16sh_pkg::SampleAllLimit) return 1'b1;
    if (idx < u16sh_pkg::WindowUnits) return 1'b1;
    if (idx >= mid && idx - mid < u16sh_pkg::WindowUnits) return 1'b1;
    return idx >= len - u16sh_pkg::WindowUnits;
  endfunction

  function automatic void predict_hash(input logic op_v, input logic [15:0] cu,
                                       input logic [31:0] bl, input logic [31:0] ol);
    if (op_v == u16sh_pkg::OP_BEGIN) begin
      request_count++;
      open_model  = 1'b0;
      pos_model   = 32'd0;
      shift_model = ol[4:0];
      acc_model   = ol;
      count_model = bl;
      if (ol == 32'd0) begin
        expected_hashes.push_back(32'd0);
      end else if (bl == 32'd0) begin
        expected_hashes.push_back(finalise_hash(ol, ol[4:0]));
      end else begin
        open_model = 1'b1;
      end
    end else if (open_model) begin
      request_count++;
      if (unit_sampled(pos_model, count_model)) begin
        acc_model = acc_model * HashMultiplier + {16'd0, cu};
      end
      pos_model = pos_model + 32'd1;
      if (pos_model >= count_model) begin
        open_model = 1'b0;
        expected_hashes.push_back(finalise_hash(acc_model, shift_model));
      end
    end
  endfunction

  function automatic logic [15:0] draw_unit();
    logic [15:0] r;
    r = 16'($urandom());
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return r;
    endcase
  endfunction

  function automatic logic [31:0] draw_length();
    logic [31:0] r;
    r = ($urandom_range(0, 1) == 0) ? $urandom() : $urandom_range(1, 300);
    return (r == 32'd0) ? 32'd1 : r;
  endfunction

  task automatic report_mismatch(input string what);
    if (error_count < ReportLimit) $display("ERROR at %0t: %s", $time, what);
    error_count++;
  endtask

  task automatic send_request(input logic op_v, input logic [15:0] cu,
                              input logic [31:0] bl, input logic [31:0] ol);
    int gap;
    gap = $urandom_range(0, tx_max_gap);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    op              = op_v;
    code_unit       = cu;
    buffer_length   = bl;
    original_length = ol;
    in_valid        = 1'b1;
    do @(posedge clk); while (in_stall);
    predict_hash(op_v, cu, bl, ol);
  endtask

  task automatic send_begin(input logic [31:0] bl, input logic [31:0] ol);
    send_request(u16sh_pkg::OP_BEGIN, draw_unit(), bl, ol);
  endtask

  task automatic send_unit(input logic [15:0] cu);
    send_request(u16sh_pkg::OP_UNIT, cu, $urandom(), $urandom());
  endtask

  task automatic send_string(input int units, input logic [31:0] ol);
    send_begin(units, ol);
    repeat (units) send_unit(draw_unit());
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_hashes.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    tx_max_gap   = MaxWait;
    rx_max_stall = MaxWait;
    send_unit(16'hFFFF);
    send_begin(32'd5, 32'd0);
    send_unit(16'h0000);
    send_begin(32'd0, 32'd0);
    send_begin(32'd0, 32'hFFFF_FFFF);
    send_begin(32'd0, 32'd33);
    send_begin(32'hFFFF_FFFF, 32'd32);
    send_begin(32'd2, 32'd1);
    send_unit(16'h0000);
    send_unit(16'hFFFF);
    send_begin(32'd3, 32'd7);
    send_unit(16'h1234);
    send_begin(32'd1, 32'h0000_0020);
    send_unit(16'hABCD);
    send_begin(32'd1, 32'hFFFF_FFFF);
    send_unit(16'hFFFF);
    send_begin(32'd4, 32'h8000_001F);
    repeat (4) send_unit(16'hFFFF);
    wait_for_results();
  endtask

  task automatic test_random_strings();
    int kind;
    int first;
    logic [31:0] ol;
    first = request_count;
    while (request_count < first + RandomRequests) begin
      kind         = $urandom_range(0, 99);
      tx_max_gap   = ($urandom_range(0, 3) == 0) ? 0 : MaxWait;
      rx_max_stall = ($urandom_range(0, 3) == 0) ? 0 : MaxWait;
      ol           = draw_length();
      if (kind < 65) begin
        send_string($urandom_range(1, 12), ol);
      end else if (kind < 72) begin
        send_string($urandom_range(90, 100), ol);
      end else if (kind < 80) begin
        if ($urandom_range(0, 1) == 0) send_begin(32'd0, ($urandom_range(0, 1) == 0) ? 32'd0 : ol);
        else send_begin($urandom(), 32'd0);
      end else if (kind < 92) begin
        send_begin($urandom(), ol);
        repeat ($urandom_range(0, 5)) send_unit(draw_unit());
      end else begin
        repeat ($urandom_range(1, 3)) send_unit(draw_unit());
      end
    end
    wait_for_results();
  endtask

  task automatic test_long_buffers();
    int long_sizes[3] = '{96, 97, 129};
    tx_max_gap   = 2;
    rx_max_stall = MaxWait;
    foreach (long_sizes[i]) send_string(long_sizes[i], draw_length());
    wait_for_results();
  endtask

  task automatic test_output_hold_off();
    tx_max_gap   = 0;
    rx_max_stall = 0;
    hold_left    = 100;
    repeat (15) begin
      send_string($urandom_range(1, 2), draw_length());
      send_begin($urandom(), 32'd0);
    end
    wait_for_results();
    tx_max_gap   = MaxWait;
    rx_max_stall = MaxWait;
  endtask

  // The receiver stalls for a drawn number of cycles after each result, and
  // holds off entirely while a long hold is counting down.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (rx_wait > 0) begin
        out_stall = 1'b1;
        rx_wait--;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_hashes.size() == 0) begin
        report_mismatch($sformatf("hash_value %h with no string pending", hash_value));
      end else begin
        oldest_hash = expected_hashes.pop_front();
        if (hash_value !== oldest_hash) begin
          report_mismatch($sformatf("hash_value %h, expected %h", hash_value, oldest_hash));
        end
      end
      rx_wait = $urandom_range(0, rx_max_stall);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    rst             = 1'b1;
    in_valid        = 1'b0;
    op              = u16sh_pkg::OP_BEGIN;
    code_unit       = 16'd0;
    buffer_length   = 32'd0;
    original_length = 32'd0;
    acc_model       = 32'd0;
    pos_model       = 32'd0;
    count_model     = 32'd0;
    shift_model     = 5'd0;
    open_model      = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed_cases();
    test_random_strings();
    test_long_buffers();
    test_output_hold_off();
    if (expected_hashes.size() != 0) report_mismatch("results still pending at the end");
    if (error_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/u16sh_pkg.sv
rtl/core/u16sh_sampler.sv
rtl/core/u16sh_core.sv
rtl/core/utf16_sampled_string_hash_unit.sv
rtl/core/u16sh_checker.sv
tb/sv/tb_utf16_sampled_string_hash_unit.sv
